// File: rtl/core/vtt_pkg.sv
// ----------------------------------------------------------------------------
// vtt_pkg: shared types and constants for the timestamp field parser
// Character codes, widths and the record that the parser front end hands to
// the result stage through the queue.
// ----------------------------------------------------------------------------
package vtt_pkg;

  localparam int unsigned ACC_BITS_DEF = 64;
  localparam int unsigned HOURS_W      = 64;
  localparam int unsigned MIN_W        = 6;
  localparam int unsigned SEC_W        = 6;
  localparam int unsigned MILLIS_W     = 10;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CAP_W        = 8;
  localparam int unsigned SIG_W        = 5;  // up to 20 significant digits
  localparam int unsigned Q_DEPTH      = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'hFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int unsigned MAX_MS_VALUE = 59;
  localparam int unsigned LEN_BASE     = 10;
  localparam int unsigned MIN_DIGITS   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NO_ROOM   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_INT  = 4'b0001,
    PH_FRAC = 4'b0010,
    PH_END  = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_e;

  // One finished token, already mapped onto hour/minute/second slots.
  typedef struct packed {
    logic                malformed;
    logic                min_big;
    logic                sec_big;
    logic [SIG_W-1:0]    hour_sig;
    logic [HOURS_W-1:0]  hours;
    logic [MIN_W-1:0]    minutes;
    logic [SEC_W-1:0]    seconds;
    logic [MILLIS_W-1:0] millis;
  } rec_t;

endpackage

// File: rtl/core/vtt_front.sv
// ----------------------------------------------------------------------------
// vtt_front: character parser
// Accumulates colon-separated decimal fields and the three fraction digits,
// and at the terminator pushes one token record into the queue.
// ----------------------------------------------------------------------------
module vtt_front
  import vtt_pkg::*;
#(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ch_valid_i,
  output logic       ch_ready_o,
  input  logic [7:0] ch_i,
  input  logic       q_full_i,
  output logic       push_o,
  output rec_t       rec_o
);

  phase_e               phase_q, phase_d;
  logic [1:0]           count_q, count_d;
  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic                 has_q, has_d;
  logic [SIG_W-1:0]     sig_q, sig_d;
  logic [1:0]           fcnt_q, fcnt_d;
  logic [MILLIS_W-1:0]  frac_q, frac_d;

  // field store: first slot full width, the others only need six bits
  logic [ACC_BITS-1:0]  slot0_q, slot0_d;
  logic [MIN_W-1:0]     slot1_q, slot1_d;
  logic [SEC_W-1:0]     slot2_q, slot2_d;
  logic [2:0]           big_q, big_d;
  logic [SIG_W-1:0]     sig0_q, sig0_d;

  logic                 accept;
  logic                 is_digit;
  logic [ACC_BITS-1:0]  digit;
  logic [ACC_BITS+3:0]  prod;
  logic                 ovf;
  logic                 acc_big;
  logic [MILLIS_W-1:0]  frac_next;

  assign ch_ready_o = !q_full_i;
  assign accept     = ch_valid_i && ch_ready_o;
  assign is_digit   = ch_i inside {[CH_ZERO:CH_NINE]};
  assign digit      = ACC_BITS'(ch_i - CH_ZERO);

  // acc*10 + d; any bit above the field width means the field overflowed
  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {4'b0, digit};
  assign ovf  = |prod[ACC_BITS+3:ACC_BITS];

  assign acc_big   = acc_q > ACC_BITS'(MAX_MS_VALUE);
  assign frac_next = (frac_q << 3) + (frac_q << 1) + MILLIS_W'(ch_i - CH_ZERO);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    acc_d   = acc_q;
    has_d   = has_q;
    sig_d   = sig_q;
    fcnt_d  = fcnt_q;
    frac_d  = frac_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    slot2_d = slot2_q;
    big_d   = big_q;
    sig0_d  = sig0_q;
    push_o  = 1'b0;

    rec_o.malformed = (phase_q != PH_END);
    rec_o.millis    = frac_q;
    if (count_q == 2'd3) begin
      rec_o.hours    = HOURS_W'(slot0_q);
      rec_o.hour_sig = sig0_q;
      rec_o.minutes  = slot1_q;
      rec_o.min_big  = big_q[1];
      rec_o.seconds  = slot2_q;
      rec_o.sec_big  = big_q[2];
    end else begin
      rec_o.hours    = '0;
      rec_o.hour_sig = '0;
      rec_o.minutes  = slot0_q[MIN_W-1:0];
      rec_o.min_big  = big_q[0];
      rec_o.seconds  = slot1_q;
      rec_o.sec_big  = big_q[1];
    end

    if (accept) begin
      if (ch_i == CH_NUL) begin
        // emit and start a fresh token
        push_o  = 1'b1;
        phase_d = PH_INT;
        count_d = '0;
        acc_d   = '0;
        has_d   = 1'b0;
        sig_d   = '0;
        fcnt_d  = '0;
        frac_d  = '0;
      end else begin
        case (phase_q)
          PH_INT: begin
            if (is_digit) begin
              if (ovf) begin
                phase_d = PH_ERR;
              end else begin
                acc_d = prod[ACC_BITS-1:0];
                has_d = 1'b1;
                // leading zeros add no significant digit
                if (sig_q != '0 || digit != '0) begin
                  sig_d = sig_q + SIG_W'(1);
                end
              end
            end else if ((ch_i == CH_COLON && (!has_q || count_q >= 2'd2)) ||
                         (ch_i == CH_DOT && (!has_q || count_q == 2'd0 ||
                                             count_q == 2'd3))) begin
              phase_d = PH_ERR;
            end else if (ch_i == CH_COLON || ch_i == CH_DOT) begin
              case (count_q)
                2'd0: begin
                  slot0_d  = acc_q;
                  big_d[0] = acc_big;
                  sig0_d   = sig_q;
                end
                2'd1: begin
                  slot1_d  = acc_q[MIN_W-1:0];
                  big_d[1] = acc_big;
                end
                default: begin
                  slot2_d  = acc_q[SEC_W-1:0];
                  big_d[2] = acc_big;
                end
              endcase
              count_d = count_q + 2'd1;
              acc_d   = '0;
              has_d   = 1'b0;
              sig_d   = '0;
              if (ch_i == CH_DOT) begin
                phase_d = PH_FRAC;
              end
            end else begin
              phase_d = PH_ERR;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              frac_d = frac_next;
              fcnt_d = fcnt_q + 2'd1;
              if (fcnt_q == 2'd2) begin
                phase_d = PH_END;
              end
            end else begin
              phase_d = PH_ERR;
            end
          end
          PH_END: begin
            phase_d = PH_ERR;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INT;
      count_q <= '0;
      acc_q   <= '0;
      has_q   <= 1'b0;
      sig_q   <= '0;
      fcnt_q  <= '0;
      frac_q  <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      acc_q   <= acc_d;
      has_q   <= has_d;
      sig_q   <= sig_d;
      fcnt_q  <= fcnt_d;
      frac_q  <= frac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
    slot2_q <= slot2_d;
    big_q   <= big_d;
    sig0_q  <= sig0_d;
  end

endmodule

// File: rtl/core/vtt_queue.sv
// ----------------------------------------------------------------------------
// vtt_queue: short token record queue
// Decouples the parser from the result stage so each can stall on its own.
// ----------------------------------------------------------------------------
module vtt_queue
  import vtt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t rec_o
);

  localparam int unsigned PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(Q_DEPTH + 1);

  rec_t              mem_q [Q_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Q_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Q_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

// File: rtl/core/vtt_back.sv
// ----------------------------------------------------------------------------
// vtt_back: result stage
// Range-checks minutes and seconds, sizes the text form against the
// capacity register and holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module vtt_back
  import vtt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i,
  input  logic                q_valid_i,
  input  rec_t                q_rec_i,
  output logic                q_pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [HOURS_W-1:0]  hours_o,
  output logic [MIN_W-1:0]    minutes_o,
  output logic [SEC_W-1:0]    seconds_o,
  output logic [MILLIS_W-1:0] millis_o,
  output logic [LEN_W-1:0]    text_length_o
);

  logic [CAP_W-1:0]    cap_q;
  logic                valid_q;
  status_e             status_q, status_d;
  logic [HOURS_W-1:0]  hours_q, hours_d;
  logic [MIN_W-1:0]    min_q, min_d;
  logic [SEC_W-1:0]    sec_q, sec_d;
  logic [MILLIS_W-1:0] ms_q, ms_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [LEN_W-1:0]    len;

  assign q_pop_o = q_valid_i && (!valid_q || res_ready_i);

  // pad hours to two digits, plus the fixed ":MM:SS,mmm" part
  assign len = ((q_rec_i.hour_sig < SIG_W'(MIN_DIGITS)) ? LEN_W'(MIN_DIGITS)
                                                        : LEN_W'(q_rec_i.hour_sig))
               + LEN_W'(LEN_BASE);

  always_comb begin
    if (q_rec_i.malformed) begin
      status_d = ST_MALFORMED;
    end else if (q_rec_i.min_big || q_rec_i.sec_big) begin
      status_d = ST_RANGE;
    end else if (CAP_W'(len) >= cap_q) begin
      status_d = ST_NO_ROOM;
    end else begin
      status_d = ST_OK;
    end
    if (status_d == ST_OK) begin
      hours_d = q_rec_i.hours;
      min_d   = q_rec_i.minutes;
      sec_d   = q_rec_i.seconds;
      ms_d    = q_rec_i.millis;
      len_d   = len;
    end else begin
      hours_d = '0;
      min_d   = '0;
      sec_d   = '0;
      ms_d    = '0;
      len_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        valid_q <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      status_q <= status_d;
      hours_q  <= hours_d;
      min_q    <= min_d;
      sec_q    <= sec_d;
      ms_q     <= ms_d;
      len_q    <= len_d;
    end
  end

  assign res_valid_o   = valid_q;
  assign status_o      = status_q;
  assign hours_o       = hours_q;
  assign minutes_o     = min_q;
  assign seconds_o     = sec_q;
  assign millis_o      = ms_q;
  assign text_length_o = len_q;

endmodule

// File: rtl/core/vtt_timestamp_to_srt_fields.sv
// ----------------------------------------------------------------------------
// vtt_timestamp_to_srt_fields: timestamp token to SubRip field values
// Parses MM:SS.mmm or HH:MM:SS.mmm one character per word and reports the
// numeric fields, a status and the SubRip text length per token.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one character per word; a zero byte ends the
//   token. Other characters produce nothing on the master stream. Each
//   terminator produces exactly one result word.
//   Throughput: one character per clock while the record queue has room,
//   including back-to-back terminators. The parser updates its field
//   accumulator (a shift-add and an overflow compare) in the cycle the
//   character is accepted. Path: a result reaches the master stream
//   through the record queue and then the output register, and both can
//   hold while the receiver stalls.
//   Stall: when the receiver holds tready low, the output register holds,
//   then the two-entry record queue fills; once it is full, s_axis_tready_o
//   drops until a result is taken.
//   Reset: the parser starts on a fresh token, the queue and output are
//   empty and out_capacity returns to 255. Write out_capacity through
//   cfg_we_i/cfg_wdata_i only while no token is in flight.
// ----------------------------------------------------------------------------
module vtt_timestamp_to_srt_fields
  import vtt_pkg::*;
#(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,     // out_capacity
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,  // [7:0] ch
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [1:0] status, [65:2] hours, [71:66] minutes, [77:72] seconds,
  // [87:78] millis, [92:88] text_length, [95:93] zero
  output logic [95:0]      m_axis_tdata_o
);

  logic                push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  rec_t                push_rec;
  rec_t                q_rec;
  logic [STATUS_W-1:0] status;
  logic [HOURS_W-1:0]  hours;
  logic [MIN_W-1:0]    minutes;
  logic [SEC_W-1:0]    seconds;
  logic [MILLIS_W-1:0] millis;
  logic [LEN_W-1:0]    text_length;

  vtt_front #(
    .ACC_BITS(ACC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ch_valid_i (s_axis_tvalid_i),
    .ch_ready_o (s_axis_tready_o),
    .ch_i       (s_axis_tdata_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  vtt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  vtt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_rec_i       (q_rec),
    .q_pop_o       (q_pop),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .status_o      (status),
    .hours_o       (hours),
    .minutes_o     (minutes),
    .seconds_o     (seconds),
    .millis_o      (millis),
    .text_length_o (text_length)
  );

  assign m_axis_tdata_o = {3'b000, text_length, millis, seconds, minutes, hours, status};

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vtt_timestamp_to_srt_fields
// Streams timestamp characters into the parser, some well formed, some broken
// and some plain noise. A scoreboard parses the same characters on its own
// and compares every result word field by field. out_capacity is stepped
// through its extremes between phases while the parser is idle.
// ----------------------------------------------------------------------------
module testbench;
  import vtt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned PHASE_CHARS    = 230;
  localparam int unsigned NUM_PHASES     = 8;

  // Result word layout, lowest field last.
  typedef struct packed {
    logic [2:0]          pad;
    logic [LEN_W-1:0]    text_length;
    logic [MILLIS_W-1:0] millis;
    logic [SEC_W-1:0]    seconds;
    logic [MIN_W-1:0]    minutes;
    logic [HOURS_W-1:0]  hours;
    logic [STATUS_W-1:0] status;
  } srt_word_t;

  class timestamp_board;
    logic [CAP_W-1:0]    capacity;
    phase_e              phase;
    logic [1:0]          n_fields;
    logic [63:0]         acc;
    logic                has_digit;
    logic [63:0]         fields[3];
    logic [1:0]          n_frac;
    logic [MILLIS_W-1:0] frac;
    status_e             err;
    srt_word_t           pending_results[$];
    int unsigned         failures;

    function new();
      capacity = CAP_RESET;
      failures = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_INT;
      n_fields  = '0;
      acc       = '0;
      has_digit = 1'b0;
      n_frac    = '0;
      frac      = '0;
      err       = ST_OK;
    endfunction

    function void malformed();
      err   = ST_MALFORMED;
      phase = PH_ERR;
    endfunction

    function void close_field();
      fields[n_fields % 3] = acc;
      n_fields  = n_fields + 2'd1;
      acc       = '0;
      has_digit = 1'b0;
    endfunction

    function void int_char(logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - CH_ZERO);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        // reject a digit that would carry past 64 bits
        if (acc > ({64{1'b1}} - d) / 64'd10) begin
          malformed();
        end else begin
          acc       = acc * 64'd10 + d;
          has_digit = 1'b1;
        end
      end else if (c == CH_COLON) begin
        if (!has_digit || n_fields >= 2) malformed();
        else close_field();
      end else if (c == CH_DOT) begin
        if (!has_digit || n_fields < 1 || n_fields > 2) begin
          malformed();
        end else begin
          close_field();
          phase = PH_FRAC;
        end
      end else begin
        malformed();
      end
    endfunction

    function int unsigned hour_width(logic [63:0] h);
      int unsigned n;
      n = 1;
      while (h >= 64'd10) begin
        h = h / 64'd10;
        n++;
      end
      return (n < MIN_DIGITS) ? MIN_DIGITS : n;
    endfunction

    function void note_char(logic [7:0] c);
      srt_word_t   r;
      logic [63:0] h, m, s;
      int unsigned len;
      if (c != CH_NUL) begin
        case (phase)
          PH_INT: int_char(c);
          PH_FRAC: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              frac   = MILLIS_W'(frac * 10 + (c - CH_ZERO));
              n_frac = n_frac + 2'd1;
              if (n_frac == 2'd3) phase = PH_END;
            end else begin
              malformed();
            end
          end
          PH_END: malformed();
          default: ;
        endcase
        return;
      end
      r = '0;
      r.status = ST_OK;
      if (phase == PH_ERR) begin
        r.status = err;
      end else if (phase != PH_END) begin
        r.status = ST_MALFORMED;
      end else begin
        h = '0;
        if (n_fields == 2'd2) begin
          m = fields[0];
          s = fields[1];
        end else begin
          h = fields[0];
          m = fields[1];
          s = fields[2];
        end
        if (m > MAX_MS_VALUE || s > MAX_MS_VALUE) begin
          r.status = ST_RANGE;
        end else begin
          len = hour_width(h) + LEN_BASE;
          if (len >= capacity) begin
            r.status = ST_NO_ROOM;
          end else begin
            r.hours       = h;
            r.minutes     = m[MIN_W-1:0];
            r.seconds     = s[SEC_W-1:0];
            r.millis      = frac;
            r.text_length = len[LEN_W-1:0];
          end
        end
      end
      pending_results.push_back(r);
      restart();
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [95:0] word);
      srt_word_t got, want;
      got = word;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: result word %h with nothing expected", $time, word);
        return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("hours", want.hours, got.hours);
      check_field("minutes", want.minutes, got.minutes);
      check_field("seconds", want.seconds, got.seconds);
      check_field("millis", want.millis, got.millis);
      check_field("text_length", want.text_length, got.text_length);
      check_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni   = 1'b0;
  logic             cfg_we   = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic             s_valid  = 1'b0;
  logic [7:0]       s_data   = '0;
  logic             m_ready  = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [95:0]      m_axis_tdata_o;

  timestamp_board board = new();
  logic [7:0]     token_chars[$];
  string          symbols = "0123456789:.";
  int unsigned    phase_chars;
  int unsigned    stall_cycles = 0;
  bit             send_burst;

  string directed_tokens[8] = '{"", ":", "1.", "1:2:3:", "1:2.3", "5:9.0001", "\377",
                                "0:0.000"};

  vtt_timestamp_to_srt_fields uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic string num_text(logic [63:0] v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 5) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic logic [63:0] clock_value();
    case ($urandom_range(0, 9))
      8: return 64'($urandom_range(60, 99));
      9: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return 64'($urandom_range(0, 59));
    endcase
  endfunction

  function automatic string hours_text();
    case ($urandom_range(0, 9))
      0: return "18446744073709551615";
      1: return "18446744073709551616";
      2: return {num_text('1), $sformatf("%0d", $urandom_range(0, 9))};
      3, 4: return num_text({$urandom, $urandom} >> $urandom_range(0, 63));
      default: return num_text(64'($urandom_range(0, 120)));
    endcase
  endfunction

  function automatic void make_token();
    string s;
    int    kind, pos, i;
    token_chars.delete();
    kind = $urandom_range(0, 19);
    if (kind < 15) begin
      s = "";
      if ($urandom_range(0, 1)) s = {hours_text(), ":"};
      s = {s, num_text(clock_value()), ":", num_text(clock_value()), ".",
           $sformatf("%03d", $urandom_range(0, 999))};
      for (i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
      // break a share of the well-formed tokens
      if (kind >= 12) begin
        pos = $urandom_range(0, token_chars.size() - 1);
        case ($urandom_range(0, 4))
          0: while (token_chars.size() > pos) void'(token_chars.pop_back());
          1: token_chars[pos] = 8'($urandom_range(1, 255));
          2: token_chars.insert(pos, symbols[$urandom_range(0, 11)]);
          3: token_chars.push_back(8'($urandom_range(1, 255)));
          default: token_chars.delete(pos);
        endcase
      end
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 12)) token_chars.push_back(symbols[$urandom_range(0, 11)]);
    end else begin
      repeat ($urandom_range(0, 8)) token_chars.push_back(8'($urandom_range(1, 255)));
    end
    token_chars.push_back(CH_NUL);
  endfunction

  task automatic send_char(logic [7:0] c);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_token_chars();
    int i;
    send_burst = ($urandom_range(0, 3) == 0);
    for (i = 0; i < token_chars.size(); i++) send_char(token_chars[i]);
    phase_chars += token_chars.size();
  endtask

  // Hold off until every result is out, then let the pipeline settle.
  task automatic drain();
    s_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.capacity = v;
  endtask

  initial begin
    logic [CAP_W-1:0] caps[NUM_PHASES];
    int               p, i;
    caps = '{8'd0, 8'd12, 8'd13, 8'd14, 8'd30, 8'd31, 8'd255, 8'd0};
    caps[3] = 8'($urandom_range(14, 29));
    caps[7] = 8'($urandom_range(0, 255));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tokens[p]) begin
      token_chars.delete();
      for (i = 0; i < directed_tokens[p].len(); i++)
        token_chars.push_back(directed_tokens[p][i]);
      token_chars.push_back(CH_NUL);
      send_token_chars();
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      set_capacity(caps[p]);
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        make_token();
        send_token_chars();
      end
    end

    drain();
    if (board.failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, with quiet stretches now and then.
  initial begin
    int unsigned gap;
    bit          sink_quiet;
    sink_quiet = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
      gap = sink_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) board.note_char(s_data);
      if (m_axis_tvalid_o && m_ready) board.check_result(m_axis_tdata_o);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

endmodule
